// ===== rtl/assert_macros.svh =====
// Assertion macros for the change-of-value filter.
// Used by the top level; expects clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCV_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("property violated");
`define PCV_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");
`else
`define PCV_ASSERT(label, prop)
`define PCV_ASSERT_NEVER(label, expr)
`endif
`endif

// ===== rtl/pcv_pkg.sv =====
// Shared types and codes for the change-of-value filter.
// No dependencies.
`timescale 1ns / 1ps
package pcv_pkg;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [2:0] KIND_BOOL   = 3'd0;
   localparam logic [2:0] KIND_DOUBLE = 3'd1;
   localparam logic [2:0] KIND_INT16  = 3'd2;
   localparam logic [2:0] KIND_UINT32 = 3'd3;
   localparam logic [2:0] KIND_FIXED  = 3'd4;

   localparam logic [2:0] REG_VALUE_KIND      = 3'd0;
   localparam logic [2:0] REG_DEADBAND_ENABLE = 3'd1;
   localparam logic [2:0] REG_DEADBAND_HUND   = 3'd2;
   localparam logic [2:0] REG_OFFLINE_INT     = 3'd3;
   localparam logic [2:0] REG_OFFLINE_TRACK   = 3'd4;
   localparam logic [2:0] REG_POINTS_IN_USE   = 3'd5;
   localparam logic [2:0] REG_QUALITY_KEPT    = 3'd6;

   localparam logic [13:0] DEADBAND_SCALE = 14'd10000;
   localparam logic [9:0]  MS_PER_S       = 10'd1000;
   localparam logic [32:0] FIXED_TOL_LSB  = 33'd6;

   typedef struct packed {
      logic [2:0]  value_kind;
      logic        deadband_enable;
      logic [13:0] deadband_hundredths;
      logic [15:0] offline_interval_s;
      logic        offline_tracking;
      logic [6:0]  points_in_use;
      logic        quality_kept;
   } pcv_cfg_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic sweep;
      logic sweep_all;
      logic load_wr;
      logic calc;
      logic mul;
      logic decide;
      logic finish;
   } pcv_cmd_type;

   typedef struct packed {
      logic match;
      logic exhausted;
      logic sweep_last;
      logic out_free;
   } pcv_sts_type;

endpackage

// ===== rtl/pcv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pcv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pcv_csr.sv =====
// Configuration registers of the change-of-value filter.
// Depends on pcv_pkg.
`timescale 1ns / 1ps
module pcv_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output pcv_pkg::pcv_cfg_type cfg
);

   pcv_pkg::pcv_cfg_type cfg_ff;
   pcv_pkg::pcv_cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pcv_pkg::REG_VALUE_KIND:      cfg_in.value_kind          = csr_wdata[2:0];
            pcv_pkg::REG_DEADBAND_ENABLE: cfg_in.deadband_enable     = csr_wdata[0];
            pcv_pkg::REG_DEADBAND_HUND:   cfg_in.deadband_hundredths = csr_wdata[13:0];
            pcv_pkg::REG_OFFLINE_INT:     cfg_in.offline_interval_s  = csr_wdata;
            pcv_pkg::REG_OFFLINE_TRACK:   cfg_in.offline_tracking    = csr_wdata[0];
            pcv_pkg::REG_POINTS_IN_USE:   cfg_in.points_in_use       = csr_wdata[6:0];
            pcv_pkg::REG_QUALITY_KEPT:    cfg_in.quality_kept        = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/pcv_ctrl.sv =====
// Controller state machine of the change-of-value filter.
// Depends on pcv_pkg; drives the datapath through command and status structs.
`timescale 1ns / 1ps
module pcv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_command,
   output logic                 req_stall,
   input  pcv_pkg::pcv_sts_type sts,
   output pcv_pkg::pcv_cmd_type cmd
);

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_LOAD   = 4'd2;
   localparam logic [3:0] ST_CLEAR  = 4'd3;
   localparam logic [3:0] ST_SCAN   = 4'd4;
   localparam logic [3:0] ST_READ   = 4'd5;
   localparam logic [3:0] ST_CALC   = 4'd6;
   localparam logic [3:0] ST_MUL    = 4'd7;
   localparam logic [3:0] ST_DECIDE = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            // zero value, quality and send-time stores after reset
            cmd.sweep     = 1'b1;
            cmd.sweep_all = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_command)
                  pcv_pkg::CMD_LOAD:   state_in = ST_LOAD;
                  pcv_pkg::CMD_UPDATE: state_in = ST_SCAN;
                  pcv_pkg::CMD_CLEAR:  state_in = ST_CLEAR;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.match) begin
               state_in = ST_READ;
            end else if (sts.exhausted) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register frees up
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/pcv_dp.sv =====
// Datapath of the change-of-value filter: point stores, address scan,
// value compare with deadband, offline send timing and result register.
// Depends on pcv_pkg and pcv_ram.
`timescale 1ns / 1ps
module pcv_dp #(
   parameter int POINTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pcv_pkg::pcv_cmd_type cmd,
   output pcv_pkg::pcv_sts_type sts,
   input  pcv_pkg::pcv_cfg_type cfg,
   input  logic [5:0]           req_slot,
   input  logic [23:0]          req_point_address,
   input  logic [31:0]          req_new_value,
   input  logic [7:0]           req_quality,
   input  logic                 req_quality_present,
   input  logic                 req_client_connected,
   input  logic [31:0]          req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic                 rsp_changed,
   output logic                 rsp_send,
   output logic [5:0]           rsp_slot_index
);

   localparam int IW = $clog2(POINTS);
   localparam int CW = $clog2(POINTS + 1);
   localparam int LW = (CW > 7) ? CW : 7;

   // captured item
   logic [5:0]  slot_ff;
   logic [23:0] addr_ff;
   logic [31:0] raw_ff;
   logic [7:0]  qual_ff;
   logic        qpres_ff;
   logic        client_ff;
   logic [31:0] now_ff;

   // scan and sweep
   logic [CW-1:0] cnt_ff;
   logic          pend_ff;
   logic [IW-1:0] pend_idx_ff;

   // working result
   logic          res_found_ff;
   logic          res_changed_ff;
   logic          res_send_ff;
   logic [IW-1:0] res_idx_ff;

   // compare pipeline
   logic        eq_ff;
   logic [32:0] diff_ff;
   logic [31:0] mag_ff;
   logic [31:0] elapsed_ff;
   logic [46:0] prod_a_ff;
   logic [46:0] prod_b_ff;
   logic [25:0] span_ff;

   // output register
   logic          rsp_valid_ff;
   logic          rsp_found_ff;
   logic          rsp_changed_ff;
   logic          rsp_send_ff;
   logic [5:0]    rsp_idx_ff;

   logic [23:0] addr_rd;
   logic [31:0] val_rd;
   logic [31:0] last_rd;

   logic [LW-1:0] limit;
   logic [LW-1:0] piu_w;
   logic          issue;
   logic          match;
   logic          slot_ok;
   logic [31:0]   nv;
   logic          same;
   logic          update_en;
   logic          send_off;
   logic [32:0]   d_w;
   logic [32:0]   o_w;
   logic [32:0]   n_w;

   logic          val_we;
   logic [IW-1:0] sweep_or_idx;
   logic [31:0]   val_wd;
   logic          qual_we;
   logic [7:0]    qual_wd;
   logic          last_we;
   logic [31:0]   last_wd;

   assign piu_w   = LW'(cfg.points_in_use);
   assign limit   = (piu_w < LW'(POINTS)) ? piu_w : LW'(POINTS);
   assign issue   = LW'(cnt_ff) < limit;
   assign match   = pend_ff && (addr_rd == addr_ff);
   assign slot_ok = {26'd0, slot_ff} < 32'(POINTS);

   assign sts.match      = match;
   assign sts.exhausted  = !pend_ff && !issue;
   assign sts.sweep_last = (cnt_ff == CW'(POINTS - 1));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cfg.value_kind)
         pcv_pkg::KIND_BOOL:   nv = {31'd0, (raw_ff != 32'd0)};
         pcv_pkg::KIND_DOUBLE: nv = {30'd0, raw_ff[1:0]};
         pcv_pkg::KIND_INT16:  nv = {16'd0, raw_ff[15:0]};
         default:              nv = raw_ff;
      endcase
   end

   // signed Q16.16 difference, one bit wider to stay exact
   assign o_w = {val_rd[31], val_rd};
   assign n_w = {nv[31], nv};
   assign d_w = o_w - n_w;

   always_comb begin
      if (cfg.value_kind <= pcv_pkg::KIND_UINT32) begin
         same = eq_ff;
      end else if (cfg.value_kind == pcv_pkg::KIND_FIXED) begin
         if (cfg.deadband_enable && (cfg.deadband_hundredths != 14'd0)) begin
            same = (prod_a_ff <= prod_b_ff);
         end else begin
            same = (diff_ff <= pcv_pkg::FIXED_TOL_LSB);
         end
      end else begin
         same = 1'b0;
      end
   end

   assign update_en = cmd.decide && !same;
   assign send_off  = !client_ff && cfg.offline_tracking && (elapsed_ff >= 32'(span_ff));

   assign sweep_or_idx = cmd.sweep ? cnt_ff[IW-1:0] : res_idx_ff;
   assign val_we  = cmd.sweep || update_en;
   assign val_wd  = cmd.sweep ? 32'd0 : nv;
   assign qual_we = cmd.sweep || (update_en && cfg.quality_kept && qpres_ff);
   assign qual_wd = cmd.sweep ? 8'd0 : qual_ff;
   assign last_we = (cmd.sweep && cmd.sweep_all) || (update_en && send_off);
   assign last_wd = cmd.sweep ? 32'd0 : now_ff;

   pcv_ram #(.WIDTH(24), .DEPTH(POINTS)) u_addr_ram (
      .clock   (clock),
      .wr_en   (cmd.load_wr && slot_ok),
      .wr_addr (IW'(slot_ff)),
      .wr_data (addr_ff),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (addr_rd)
   );

   pcv_ram #(.WIDTH(32), .DEPTH(POINTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (sweep_or_idx),
      .wr_data (val_wd),
      .rd_addr (res_idx_ff),
      .rd_data (val_rd)
   );

   pcv_ram #(.WIDTH(8), .DEPTH(POINTS)) u_quality_ram (
      .clock   (clock),
      .wr_en   (qual_we),
      .wr_addr (sweep_or_idx),
      .wr_data (qual_wd),
      .rd_addr (res_idx_ff),
      .rd_data ()
   );

   pcv_ram #(.WIDTH(32), .DEPTH(POINTS)) u_last_ram (
      .clock   (clock),
      .wr_en   (last_we),
      .wr_addr (sweep_or_idx),
      .wr_data (last_wd),
      .rd_addr (res_idx_ff),
      .rd_data (last_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slot_ff   <= req_slot;
         addr_ff   <= req_point_address;
         raw_ff    <= req_new_value;
         qual_ff   <= req_quality;
         qpres_ff  <= req_quality_present;
         client_ff <= req_client_connected;
         now_ff    <= req_now_ms;
      end
      if (cmd.scan && !match && issue) begin
         pend_idx_ff <= cnt_ff[IW-1:0];
      end
      if (cmd.calc) begin
         eq_ff      <= (val_rd == nv);
         diff_ff    <= d_w[32] ? (33'd0 - d_w) : d_w;
         mag_ff     <= val_rd[31] ? (32'd0 - val_rd) : val_rd;
         elapsed_ff <= now_ff - last_rd;
      end
      if (cmd.mul) begin
         prod_a_ff <= 47'(diff_ff) * 47'(pcv_pkg::DEADBAND_SCALE);
         prod_b_ff <= 47'(mag_ff * cfg.deadband_hundredths);
         span_ff   <= 26'(cfg.offline_interval_s) * 26'(pcv_pkg::MS_PER_S);
      end
      if (cmd.finish) begin
         rsp_found_ff   <= res_found_ff;
         rsp_changed_ff <= res_changed_ff;
         rsp_send_ff    <= res_send_ff;
         rsp_idx_ff     <= 6'(res_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         pend_ff        <= 1'b0;
         res_found_ff   <= 1'b0;
         res_changed_ff <= 1'b0;
         res_send_ff    <= 1'b0;
         res_idx_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.capture) begin
            cnt_ff         <= '0;
            pend_ff        <= 1'b0;
            res_found_ff   <= 1'b0;
            res_changed_ff <= 1'b0;
            res_send_ff    <= 1'b0;
            res_idx_ff     <= '0;
         end else if (cmd.sweep) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (cmd.scan) begin
            if (match) begin
               // stop on the lowest matching slot
               res_found_ff <= 1'b1;
               res_idx_ff   <= pend_idx_ff;
            end else if (issue) begin
               cnt_ff  <= cnt_ff + CW'(1);
               pend_ff <= 1'b1;
            end else begin
               pend_ff <= 1'b0;
            end
         end else if (cmd.decide) begin
            res_changed_ff <= update_en;
            res_send_ff    <= update_en && (client_ff || send_off);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_changed    = rsp_changed_ff;
   assign rsp_send       = rsp_send_ff;
   assign rsp_slot_index = rsp_idx_ff;

endmodule

// ===== rtl/point_change_of_value_filter.sv =====
// Change-of-value filter, one item at a time. A load writes the address store,
// a clear zeros the value and quality stores of every slot, and an update scans
// the stored addresses serially, then reads the matched point and compares it
// in the calc, mul and decide steps. The next item is taken while a result waits.
// Reset (synchronous) clears the state, configuration and result registers, then
// a sweep zeros the value, quality and send-time stores before any item is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module point_change_of_value_filter #(
   parameter int POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_slot,
   input  logic [23:0] req_point_address,
   input  logic [31:0] req_new_value,
   input  logic [7:0]  req_quality,
   input  logic        req_quality_present,
   input  logic        req_client_connected,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic        rsp_changed,
   output logic        rsp_send,
   output logic [5:0]  rsp_slot_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   pcv_pkg::pcv_cfg_type cfg;
   pcv_pkg::pcv_cmd_type cmd;
   pcv_pkg::pcv_sts_type sts;

   pcv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcv_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   pcv_dp #(.POINTS(POINTS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .cfg                  (cfg),
      .req_slot             (req_slot),
      .req_point_address    (req_point_address),
      .req_new_value        (req_new_value),
      .req_quality          (req_quality),
      .req_quality_present  (req_quality_present),
      .req_client_connected (req_client_connected),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_changed          (rsp_changed),
      .rsp_send             (rsp_send),
      .rsp_slot_index       (rsp_slot_index)
   );

   `PCV_ASSERT(a_accept_then_busy, (req_valid && !req_stall) |=> req_stall)
   `PCV_ASSERT_NEVER(a_send_needs_change, rsp_valid && rsp_send && !rsp_changed)
   `PCV_ASSERT_NEVER(a_change_needs_match, rsp_valid && rsp_changed && !rsp_found)
   `PCV_ASSERT_NEVER(a_miss_index_zero, rsp_valid && !rsp_found && (rsp_slot_index != 6'd0))

endmodule
